### rtl/core/kvi_pkg.sv
package kvi_pkg;

   localparam int MAX_KEYS  = 64;
   localparam int KEY_IDX_W = $clog2(MAX_KEYS);
   localparam int KEY_CNT_W = 7;
   localparam int DATA_W    = 32;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [1:0] COMP_X = 2'd0;
   localparam logic [1:0] COMP_Y = 2'd1;
   localparam logic [1:0] COMP_Z = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] key_time;
      logic [DATA_W-1:0] x;
      logic [DATA_W-1:0] y;
      logic [DATA_W-1:0] z;
   } key_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RD_A,
      ST_GOT_A,
      ST_DIV,
      ST_BLEND,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W:0]   dt;
      logic [DATA_W:0]   span;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] frac;
   } div_rsp_type;

   typedef struct packed {
      logic              valid;
      logic [1:0]        comp;
      logic [DATA_W-1:0] va;
      logic [DATA_W-1:0] vb;
      logic [DATA_W-1:0] frac;
   } blend_req_type;

   typedef struct packed {
      logic              valid;
      logic [1:0]        comp;
      logic [DATA_W-1:0] result;
   } blend_rsp_type;

endpackage

### rtl/core/kvi_key_store.sv
module kvi_key_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [kvi_pkg::KEY_IDX_W-1:0] wr_addr,
   input  kvi_pkg::key_entry_type        wr_data,
   input  logic                          rd_en,
   input  logic [kvi_pkg::KEY_IDX_W-1:0] rd_addr,
   output kvi_pkg::key_entry_type        rd_data
);

   kvi_pkg::key_entry_type mem [kvi_pkg::MAX_KEYS];
   kvi_pkg::key_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/kvi_div_unit.sv
module kvi_div_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  kvi_pkg::div_req_type div_req,
   output kvi_pkg::div_rsp_type div_rsp
);

   localparam int QW = kvi_pkg::DATA_W + 16;
   localparam int DW = kvi_pkg::DATA_W;

   // dividend magnitude is |dt| * 2^16, quotient shifts in at the bottom
   logic [QW-1:0]          dvd_ff, dvd_in;
   logic [DW-1:0]          rem_ff, rem_in;
   logic [DW-1:0]          dsr_ff, dsr_in;
   logic                   neg_ff, neg_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [$clog2(QW)-1:0]  cnt_ff, cnt_in;

   logic [DW:0]            trial;
   logic [DW:0]            trial_sub;
   logic [DW-1:0]          mag_dt;
   logic [DW-1:0]          mag_span;
   logic [DW-1:0]          frac;

   always_comb begin
      mag_dt   = div_req.dt[DW] ? DW'(-div_req.dt) : div_req.dt[DW-1:0];
      mag_span = div_req.span[DW] ? DW'(-div_req.span) : div_req.span[DW-1:0];
      trial     = {rem_ff, dvd_ff[QW-1]};
      trial_sub = trial - {1'b0, dsr_ff};

      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;

      if (div_req.start) begin
         dvd_in  = {mag_dt, 16'd0};
         rem_in  = '0;
         dsr_in  = mag_span;
         neg_in  = div_req.dt[DW] ^ div_req.span[DW];
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (!trial_sub[DW]) begin
            rem_in = trial_sub[DW-1:0];
            dvd_in = {dvd_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            dvd_in = {dvd_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(QW))'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   // sign and saturate the quotient to signed 32 bits
   always_comb begin
      if (!neg_ff) begin
         if (dvd_ff[QW-1:DW-1] != '0) begin
            frac = {1'b0, {(DW-1){1'b1}}};
         end else begin
            frac = dvd_ff[DW-1:0];
         end
      end else begin
         if (dvd_ff[QW-1:DW] != '0 || (dvd_ff[DW-1] && dvd_ff[DW-2:0] != '0)) begin
            frac = {1'b1, {(DW-1){1'b0}}};
         end else begin
            frac = DW'(0) - dvd_ff[DW-1:0];
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.frac = frac;

endmodule

### rtl/core/kvi_blend_unit.sv
module kvi_blend_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  kvi_pkg::blend_req_type blend_req,
   output kvi_pkg::blend_rsp_type blend_rsp
);

   localparam int DW = kvi_pkg::DATA_W;
   localparam int PW = 2 * DW + 1;
   localparam int QW = PW - 16;
   localparam int SW = QW + 1;

   logic [3:0]          vld_ff;
   logic [1:0]          comp1_ff, comp2_ff, comp3_ff, comp4_ff;
   logic [DW-1:0]       va1_ff, va2_ff, va3_ff;
   logic [DW-1:0]       frac1_ff;
   logic signed [DW:0]  dv_ff, dv_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [PW-1:0]       prod_adj;
   logic [QW-1:0]       q_ff, q_in;
   logic [SW-1:0]       sum;
   logic [DW-1:0]       res_ff, res_in;

   always_comb begin
      dv_in   = $signed({blend_req.vb[DW-1], blend_req.vb})
              - $signed({blend_req.va[DW-1], blend_req.va});
      prod_in = dv_ff * $signed(frac1_ff);
      // truncate toward zero on the divide by 2^16
      prod_adj = prod_ff + {{(PW-16){1'b0}}, {16{prod_ff[PW-1]}}};
      q_in     = prod_adj[PW-1:16];
      sum      = {q_ff[QW-1], q_ff} + {{(SW-DW){va3_ff[DW-1]}}, va3_ff};
      if (sum[SW-1:DW-1] != {(SW-DW+1){sum[SW-1]}}) begin
         res_in = sum[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
         res_in = sum[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], blend_req.valid};
      end
   end

   always_ff @(posedge clock) begin
      dv_ff    <= dv_in;
      va1_ff   <= blend_req.va;
      frac1_ff <= blend_req.frac;
      comp1_ff <= blend_req.comp;
      prod_ff  <= prod_in;
      va2_ff   <= va1_ff;
      comp2_ff <= comp1_ff;
      q_ff     <= q_in;
      va3_ff   <= va2_ff;
      comp3_ff <= comp2_ff;
      res_ff   <= res_in;
      comp4_ff <= comp3_ff;
   end

   assign blend_rsp.valid  = vld_ff[3];
   assign blend_rsp.comp   = comp4_ff;
   assign blend_rsp.result = res_ff;

endmodule

### rtl/core/keyframe_vector_interpolator.sv
// Keyframe write: accepted back to back while no sample is in progress, no response.
// Sample: the linear key search (one key per cycle) finds the key at position
// N (up to 63); the serial divider (one quotient bit per cycle, 48 bits) runs
// when the sample lies between two keys. One request at a time.
// Reset (synchronous, active high) idles the sequencer, clears the response
// valid and sets key_count to 1; the key table is not cleared.
module keyframe_vector_interpolator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic [kvi_pkg::KEY_IDX_W-1:0]       req_key_index,
   input  logic [kvi_pkg::DATA_W-1:0]          req_key_time,
   input  logic signed [kvi_pkg::DATA_W-1:0]   req_value_x,
   input  logic signed [kvi_pkg::DATA_W-1:0]   req_value_y,
   input  logic signed [kvi_pkg::DATA_W-1:0]   req_value_z,
   input  logic [kvi_pkg::DATA_W-1:0]          req_sample_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [kvi_pkg::DATA_W-1:0]   rsp_out_x,
   output logic signed [kvi_pkg::DATA_W-1:0]   rsp_out_y,
   output logic signed [kvi_pkg::DATA_W-1:0]   rsp_out_z,
   input  logic                                csr_write_enable,
   input  logic [kvi_pkg::KEY_CNT_W-1:0]       csr_write_data
);

   localparam int DW = kvi_pkg::DATA_W;
   localparam int CW = kvi_pkg::KEY_CNT_W;
   localparam int IW = kvi_pkg::KEY_IDX_W;

   kvi_pkg::state_type     state_ff, state_in;
   logic [CW-1:0]          key_count_ff, key_count_in;
   logic [CW-1:0]          n_ff, n_in;
   logic [CW-1:0]          n_clamp;
   logic [CW-1:0]          k_ff, k_in;
   logic [CW-1:0]          chk_idx_ff, chk_idx_in;
   logic                   chk_valid_ff, chk_valid_in;
   logic [IW-1:0]          a_idx_ff, a_idx_in;
   logic                   interp_ff, interp_in;
   logic [1:0]             comp_ff, comp_in;
   logic [DW-1:0]          st_ff, st_in;
   logic [DW-1:0]          frac_ff, frac_in;
   kvi_pkg::key_entry_type b_ff, b_in;
   logic [DW-1:0]          res_x_ff, res_x_in;
   logic [DW-1:0]          res_y_ff, res_y_in;
   logic [DW-1:0]          res_z_ff, res_z_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]          rsp_x_ff, rsp_x_in;
   logic [DW-1:0]          rsp_y_ff, rsp_y_in;
   logic [DW-1:0]          rsp_z_ff, rsp_z_in;

   logic                   req_accept;
   logic                   mem_wr_en;
   kvi_pkg::key_entry_type mem_wr_data;
   logic                   mem_rd_en;
   logic [IW-1:0]          mem_rd_addr;
   kvi_pkg::key_entry_type rd;
   logic [DW:0]            span;
   logic [DW:0]            dt;

   kvi_pkg::div_req_type   div_req;
   kvi_pkg::div_rsp_type   div_rsp;
   kvi_pkg::blend_req_type blend_req;
   kvi_pkg::blend_rsp_type blend_rsp;

   kvi_key_store u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (req_key_index),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (rd)
   );

   kvi_div_unit u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   kvi_blend_unit u_blend (
      .clock     (clock),
      .reset     (reset),
      .blend_req (blend_req),
      .blend_rsp (blend_rsp)
   );

   assign req_stall  = (state_ff != kvi_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign mem_wr_en           = req_accept && (req_op == kvi_pkg::OP_WRITE);
   assign mem_wr_data.key_time = req_key_time;
   assign mem_wr_data.x        = req_value_x;
   assign mem_wr_data.y        = req_value_y;
   assign mem_wr_data.z        = req_value_z;

   // rd holds key a during GOT_A and the blend phase
   assign span = {1'b0, b_ff.key_time} - {1'b0, rd.key_time};
   assign dt   = {1'b0, st_ff} - {1'b0, rd.key_time};

   always_comb begin
      if (key_count_ff == '0) begin
         n_clamp = CW'(1);
      end else if (key_count_ff > CW'(kvi_pkg::MAX_KEYS)) begin
         n_clamp = CW'(kvi_pkg::MAX_KEYS);
      end else begin
         n_clamp = key_count_ff;
      end
   end

   always_comb begin
      key_count_in = csr_write_enable ? csr_write_data : key_count_ff;

      state_in     = state_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      chk_idx_in   = chk_idx_ff;
      chk_valid_in = 1'b0;
      a_idx_in     = a_idx_ff;
      interp_in    = interp_ff;
      comp_in      = comp_ff;
      st_in        = st_ff;
      frac_in      = frac_ff;
      b_in         = b_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_z_in     = res_z_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = a_idx_ff;

      div_req.start = 1'b0;
      div_req.dt    = dt;
      div_req.span  = span;

      blend_req.valid = 1'b0;
      blend_req.comp  = comp_ff;
      blend_req.frac  = frac_ff;
      unique case (comp_ff)
         kvi_pkg::COMP_X: begin
            blend_req.va = rd.x;
            blend_req.vb = b_ff.x;
         end
         kvi_pkg::COMP_Y: begin
            blend_req.va = rd.y;
            blend_req.vb = b_ff.y;
         end
         default: begin
            blend_req.va = rd.z;
            blend_req.vb = b_ff.z;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;

      if (blend_rsp.valid) begin
         unique case (blend_rsp.comp)
            kvi_pkg::COMP_X: res_x_in = blend_rsp.result;
            kvi_pkg::COMP_Y: res_y_in = blend_rsp.result;
            default:         res_z_in = blend_rsp.result;
         endcase
      end

      unique case (state_ff)
         kvi_pkg::ST_IDLE: begin
            if (req_accept && req_op == kvi_pkg::OP_SAMPLE) begin
               st_in = req_sample_time;
               n_in  = n_clamp;
               if (n_clamp == CW'(1)) begin
                  a_idx_in  = '0;
                  interp_in = 1'b0;
                  state_in  = kvi_pkg::ST_RD_A;
               end else begin
                  k_in     = CW'(1);
                  state_in = kvi_pkg::ST_SEARCH;
               end
            end
         end
         kvi_pkg::ST_SEARCH: begin
            // read key k while checking key k-1 returned from the last read
            mem_rd_en    = 1'b1;
            mem_rd_addr  = k_ff[IW-1:0];
            k_in         = k_ff + 1'b1;
            chk_idx_in   = k_ff;
            chk_valid_in = 1'b1;
            if (chk_valid_ff) begin
               if (st_ff < rd.key_time) begin
                  b_in      = rd;
                  a_idx_in  = IW'(chk_idx_ff - 1'b1);
                  interp_in = 1'b1;
                  state_in  = kvi_pkg::ST_RD_A;
               end else if (chk_idx_ff == n_ff - 1'b1) begin
                  a_idx_in  = IW'(n_ff - 1'b1);
                  interp_in = 1'b0;
                  state_in  = kvi_pkg::ST_RD_A;
               end
            end
         end
         kvi_pkg::ST_RD_A: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = a_idx_ff;
            state_in    = kvi_pkg::ST_GOT_A;
         end
         kvi_pkg::ST_GOT_A: begin
            if (!interp_ff || span == '0) begin
               res_x_in = rd.x;
               res_y_in = rd.y;
               res_z_in = rd.z;
               state_in = kvi_pkg::ST_DONE;
            end else begin
               div_req.start = 1'b1;
               state_in      = kvi_pkg::ST_DIV;
            end
         end
         kvi_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               frac_in  = div_rsp.frac;
               comp_in  = kvi_pkg::COMP_X;
               state_in = kvi_pkg::ST_BLEND;
            end
         end
         kvi_pkg::ST_BLEND: begin
            blend_req.valid = 1'b1;
            comp_in         = comp_ff + 1'b1;
            if (comp_ff == kvi_pkg::COMP_Z) begin
               state_in = kvi_pkg::ST_DRAIN;
            end
         end
         kvi_pkg::ST_DRAIN: begin
            if (blend_rsp.valid && blend_rsp.comp == kvi_pkg::COMP_Z) begin
               state_in = kvi_pkg::ST_DONE;
            end
         end
         kvi_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               rsp_z_in     = res_z_ff;
               state_in     = kvi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kvi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kvi_pkg::ST_IDLE;
         key_count_ff <= CW'(1);
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_count_ff <= key_count_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      k_ff       <= k_in;
      chk_idx_ff <= chk_idx_in;
      a_idx_ff   <= a_idx_in;
      interp_ff  <= interp_in;
      comp_ff    <= comp_in;
      st_ff      <= st_in;
      frac_ff    <= frac_in;
      b_ff       <= b_in;
      res_x_ff   <= res_x_in;
      res_y_ff   <= res_y_in;
      res_z_ff   <= res_z_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_z_ff   <= rsp_z_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rsp_x_ff;
   assign rsp_out_y = rsp_y_ff;
   assign rsp_out_z = rsp_z_ff;

endmodule
